>>> hw/rtl/lbs_pkg.sv
`timescale 1ns / 1ps

package lbs_pkg;

  // Operation codes carried in the input word.
  typedef enum logic [1:0] {
    OP_QUERY   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_RESTART = 2'd2,
    OP_STOP    = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_BASE_RED     = 3'd0;
  localparam logic [2:0] REG_BASE_GREEN   = 3'd1;
  localparam logic [2:0] REG_BASE_BLUE    = 3'd2;
  localparam logic [2:0] REG_BRIGHTNESS   = 3'd3;
  localparam logic [2:0] REG_SPEED_Q4     = 3'd4;
  localparam logic [2:0] REG_STRIP_LENGTH = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [9:0] SPEED_MIN_Q4   = 10'd48;
  localparam logic [9:0] SPEED_MAX_Q4   = 10'd640;
  localparam logic [10:0] ACCUM_LIMIT_Q4 = 11'd240;
  localparam logic [5:0] SPEED_FLOOR    = 6'd3;

  // Trail scale factors, already incremented by one (nscale uses s + 1).
  localparam logic [7:0] MUL_TRAIL1 = 8'd154;
  localparam logic [7:0] MUL_TRAIL2 = 8'd78;
  localparam logic [7:0] MUL_DIM    = 8'd52;

  localparam logic [7:0] RST_BASE_RED     = 8'd255;
  localparam logic [7:0] RST_BASE_GREEN   = 8'd0;
  localparam logic [7:0] RST_BASE_BLUE    = 8'd0;
  localparam logic [7:0] RST_BRIGHTNESS   = 8'd255;
  localparam logic [7:0] RST_STRIP_LENGTH = 8'd60;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] pixel_index;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] head_position;
    logic       heading_up;
  } out_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Scanner position state seen by the pixel shader.
  typedef struct packed {
    logic [7:0] head_pos;
    logic       going_up;
    logic [7:0] strip_length;
  } scan_view_t;

  // Video scaling: never rounds a lit channel down to zero.
  function automatic logic [7:0] video_scale(logic [7:0] c, logic [7:0] s);
    logic [15:0] prod;
    logic [7:0]  bump;
    prod = {8'd0, c} * {8'd0, s};
    bump = ((c != 8'd0) && (s != 8'd0)) ? 8'd1 : 8'd0;
    return prod[15:8] + bump;
  endfunction

  function automatic logic [7:0] nscale(logic [7:0] c, logic [7:0] k);
    logic [15:0] prod;
    prod = {8'd0, c} * {8'd0, k};
    return prod[15:8];
  endfunction

  // Head step: 1 + (floor(speed) - 3) * 5 / 27, by compare ladder (0..185).
  function automatic logic [2:0] step_from_speed(logic [9:0] sq);
    logic [5:0] x;
    logic [7:0] p;
    logic [2:0] q;
    x = sq[9:4] - SPEED_FLOOR;
    p = {2'd0, x} * 8'd5;
    if (p >= 8'd162)      q = 3'd6;
    else if (p >= 8'd135) q = 3'd5;
    else if (p >= 8'd108) q = 3'd4;
    else if (p >= 8'd81)  q = 3'd3;
    else if (p >= 8'd54)  q = 3'd2;
    else if (p >= 8'd27)  q = 3'd1;
    else                  q = 3'd0;
    return q + 3'd1;
  endfunction

endpackage

>>> hw/rtl/led_bounce_scanner_unit.sv
`timescale 1ns / 1ps
// Pipeline: an accepted word passes the input register, then the result register.
// Throughput: one word per cycle in each direction unless stalled; the state update is one add and compare.
// Backpressure: input stage holds while the result register is full and not taken.
// Reset (rst, synchronous, active high): registers to defaults, head 0, heading up, stopped.
// Scaled color and head step are re-derived from the registers every cycle.

module led_bounce_scanner_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lbs_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lbs_pkg::out_word_t                out_data,
  input  logic                              cfg_we,
  input  logic [lbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lbs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Configuration registers
  logic [7:0] base_red;
  logic [7:0] base_green;
  logic [7:0] base_blue;
  logic [7:0] brightness;
  logic [9:0] speed_q4;
  logic [7:0] strip_length;

  // Derived from configuration via their own register, so they trail a write. The user must
  // make config writes only while idle (not enforced by the block), so no item sees a stale value.
  lbs_pkg::rgb_t scaled;
  logic [2:0]    step;

  // Scanner state
  logic [7:0] head_pos;
  logic       going_up;
  logic       running;
  logic [9:0] delay_accum;
  logic [7:0] head_pos_next;
  logic       going_up_next;
  logic       running_next;
  logic [9:0] delay_accum_next;

  // Input stage and result register
  logic               s1_valid;
  lbs_pkg::in_word_t  s1_data;
  logic               advance;
  lbs_pkg::rgb_t      color;
  lbs_pkg::scan_view_t view;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  // ---------------------------------------------------------------------------
  // Configuration port: speed saturates, a zero strip length is stored as one,
  // indexes past the list are dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      base_red     <= lbs_pkg::RST_BASE_RED;
      base_green   <= lbs_pkg::RST_BASE_GREEN;
      base_blue    <= lbs_pkg::RST_BASE_BLUE;
      brightness   <= lbs_pkg::RST_BRIGHTNESS;
      speed_q4     <= lbs_pkg::SPEED_MIN_Q4;
      strip_length <= lbs_pkg::RST_STRIP_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        lbs_pkg::REG_BASE_RED:   base_red   <= cfg_data[7:0];
        lbs_pkg::REG_BASE_GREEN: base_green <= cfg_data[7:0];
        lbs_pkg::REG_BASE_BLUE:  base_blue  <= cfg_data[7:0];
        lbs_pkg::REG_BRIGHTNESS: brightness <= cfg_data[7:0];
        lbs_pkg::REG_SPEED_Q4: begin
          if (cfg_data < lbs_pkg::SPEED_MIN_Q4)      speed_q4 <= lbs_pkg::SPEED_MIN_Q4;
          else if (cfg_data > lbs_pkg::SPEED_MAX_Q4) speed_q4 <= lbs_pkg::SPEED_MAX_Q4;
          else                                       speed_q4 <= cfg_data;
        end
        lbs_pkg::REG_STRIP_LENGTH: begin
          strip_length <= (cfg_data[7:0] == 8'd0) ? 8'd1 : cfg_data[7:0];
        end
        default: ;
      endcase
    end
  end

  // Brightness-scaled base color and head step, refreshed every cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      scaled.red   <= lbs_pkg::video_scale(lbs_pkg::RST_BASE_RED, lbs_pkg::RST_BRIGHTNESS);
      scaled.green <= lbs_pkg::video_scale(lbs_pkg::RST_BASE_GREEN, lbs_pkg::RST_BRIGHTNESS);
      scaled.blue  <= lbs_pkg::video_scale(lbs_pkg::RST_BASE_BLUE, lbs_pkg::RST_BRIGHTNESS);
      step         <= lbs_pkg::step_from_speed(lbs_pkg::SPEED_MIN_Q4);
    end else begin
      scaled.red   <= lbs_pkg::video_scale(base_red, brightness);
      scaled.green <= lbs_pkg::video_scale(base_green, brightness);
      scaled.blue  <= lbs_pkg::video_scale(base_blue, brightness);
      step         <= lbs_pkg::step_from_speed(speed_q4);
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel shading on the word in the input stage, against current state.
  // ---------------------------------------------------------------------------
  assign view.head_pos     = head_pos;
  assign view.going_up     = going_up;
  assign view.strip_length = strip_length;

  lbs_shade u_shade (
    .item   (s1_data),
    .view   (view),
    .scaled (scaled),
    .color  (color)
  );

  // ---------------------------------------------------------------------------
  // State update for the word in the input stage.
  // ---------------------------------------------------------------------------
  logic [10:0] accum_sum;
  logic [8:0]  up_pos;
  logic [8:0]  len_m1;
  logic [9:0]  down_pos;

  assign accum_sum = {1'b0, delay_accum} + {1'b0, speed_q4};
  assign up_pos    = {1'b0, head_pos} + {6'd0, step};
  assign len_m1    = {1'b0, strip_length} - 9'd1;
  assign down_pos  = {2'b00, head_pos} - {7'd0, step};

  always_comb begin
    head_pos_next    = head_pos;
    going_up_next    = going_up;
    running_next     = running;
    delay_accum_next = delay_accum;
    case (lbs_pkg::op_t'(s1_data.op))
      lbs_pkg::OP_QUERY: ;
      lbs_pkg::OP_ADVANCE: begin
        if (running) begin
          if (accum_sum < lbs_pkg::ACCUM_LIMIT_Q4) begin
            delay_accum_next = accum_sum[9:0];
          end else begin
            delay_accum_next = '0;
            if (going_up) begin
              // Reaching or passing the last pixel turns the scanner around.
              if (up_pos >= len_m1) begin
                head_pos_next = len_m1[7:0];
                going_up_next = 1'b0;
              end else begin
                head_pos_next = up_pos[7:0];
              end
            end else begin
              // Down: at or past zero, or beyond a shrunken strip, restart at 0.
              if (down_pos[9] || (down_pos == 10'd0) ||
                  (down_pos > {2'b00, strip_length})) begin
                head_pos_next = 8'd0;
                going_up_next = 1'b1;
              end else begin
                head_pos_next = down_pos[7:0];
              end
            end
          end
        end
      end
      lbs_pkg::OP_RESTART: begin
        head_pos_next = 8'd0;
        going_up_next = 1'b1;
        running_next  = 1'b1;
      end
      lbs_pkg::OP_STOP: running_next = 1'b0;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline registers. State commits when the word moves to the result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      head_pos    <= 8'd0;
      going_up    <= 1'b1;
      running     <= 1'b0;
      delay_accum <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          head_pos    <= head_pos_next;
          going_up    <= going_up_next;
          running     <= running_next;
          delay_accum <= delay_accum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
    if (advance && s1_valid) begin
      out_data.out_red       <= color.red;
      out_data.out_green     <= color.green;
      out_data.out_blue      <= color.blue;
      out_data.head_position <= head_pos_next;
      out_data.heading_up    <= going_up_next;
    end
  end

endmodule

>>> hw/rtl/lbs_shade.sv
`timescale 1ns / 1ps

module lbs_shade (
  input  lbs_pkg::in_word_t   item,
  input  lbs_pkg::scan_view_t view,
  input  lbs_pkg::rgb_t       scaled,
  output lbs_pkg::rgb_t       color
);

  logic [8:0] idx9;
  logic [8:0] head9;
  logic [8:0] trail1;
  logic [8:0] trail2;
  logic [7:0] mul;
  logic       full;
  logic       on_strip;

  assign idx9  = {1'b0, item.pixel_index};
  assign head9 = {1'b0, view.head_pos};

  // Trail lies behind the direction of travel; 9-bit wrap keeps a head at
  // the low end from matching any real index.
  assign trail1 = view.going_up ? head9 - 9'd1 : head9 + 9'd1;
  assign trail2 = view.going_up ? head9 - 9'd2 : head9 + 9'd2;

  assign full     = (idx9 == head9);
  assign on_strip = (item.pixel_index < view.strip_length);

  always_comb begin
    if (idx9 == trail1)      mul = lbs_pkg::MUL_TRAIL1;
    else if (idx9 == trail2) mul = lbs_pkg::MUL_TRAIL2;
    else                     mul = lbs_pkg::MUL_DIM;

    color = '0;
    if ((lbs_pkg::op_t'(item.op) == lbs_pkg::OP_QUERY) && on_strip) begin
      if (full) begin
        color = scaled;
      end else begin
        color.red   = lbs_pkg::nscale(scaled.red, mul);
        color.green = lbs_pkg::nscale(scaled.green, mul);
        color.blue  = lbs_pkg::nscale(scaled.blue, mul);
      end
    end
  end

endmodule

>>> hw/rtl/lbs_checker.sv
`timescale 1ns / 1ps

module lbs_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input lbs_pkg::out_word_t  out_data
);

  // A held result word does not change.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // The input side only stalls behind a full, untaken result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // An accepted word goes through the input register to the output when the sink is ready.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 out_ready |=> out_valid)
    else $error("result word late");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind led_bounce_scanner_unit lbs_checker u_lbs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
